/* design/sdbm_pkg.sv */
// Shared types and constants for the SDBM string hash block.
// Used by sdbm_mod_unit and sdbm_string_hash_top; no dependencies.
package sdbm_pkg;

    localparam int C_HASH_W = 64;
    localparam int C_SIZE_W = 31;
    localparam int C_CNT_W  = $clog2(C_HASH_W);

    // Status of the remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

/* design/sdbm_mod_unit.sv */
// Bit-serial restoring remainder unit: 64-bit dividend modulo a 31-bit divisor.
// Takes one dividend bit per cycle. Depends on sdbm_pkg.
module sdbm_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdbm_pkg::C_HASH_W-1:0] i_dividend,
    input  logic [sdbm_pkg::C_SIZE_W-1:0] i_divisor,
    output sdbm_pkg::t_mod_stat           o_stat,
    output logic [sdbm_pkg::C_SIZE_W-1:0] o_rem
);

    localparam logic [sdbm_pkg::C_CNT_W-1:0] C_ITER_LAST =
        sdbm_pkg::C_CNT_W'(sdbm_pkg::C_HASH_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [sdbm_pkg::C_CNT_W-1:0]  r_cnt;
    logic [sdbm_pkg::C_HASH_W-1:0] r_dvd;
    logic [sdbm_pkg::C_SIZE_W-1:0] r_rem;
    logic [sdbm_pkg::C_SIZE_W-1:0] r_div;

    logic [sdbm_pkg::C_SIZE_W:0]   trial;
    logic [sdbm_pkg::C_SIZE_W:0]   diff;
    logic                          fits;
    logic [sdbm_pkg::C_SIZE_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so one compare and
    // subtract per bit keeps it in range.
    always_comb begin
        trial = {r_rem, r_dvd[sdbm_pkg::C_HASH_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[sdbm_pkg::C_SIZE_W-1:0] : trial[sdbm_pkg::C_SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_ITER_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[sdbm_pkg::C_HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("remainder unit did not start");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == C_ITER_LAST) |=> (r_done && !r_busy))
        else $error("remainder unit did not finish after the last bit");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");
`endif

endmodule

/* design/sdbm_string_hash_top.sv */
// Top level of the SDBM string hash block: sequencer, byte fold and output word.
// Depends on sdbm_pkg and sdbm_mod_unit.
//
// Usage. The input channel carries one word per byte of a name. A word with
// first_of_name set restarts the 64-bit running hash from the sign-extended
// seed; every word that is not marked no_chars folds its byte in as
// h = byte + (h << 6) + (h << 16) - h. With fold_case set, a-z are hashed as A-Z.
// The word marked last_of_name produces one output word: the hash modulo
// table_size, or the full 64-bit hash when table_size is zero.
// Timing: a word that does not end a name passes through S_FOLD back to S_IDLE.
// A word that ends a name goes from S_FOLD to S_OUT when table_size is zero; with
// a nonzero table_size it waits in S_MOD while the bit-serial remainder unit
// takes one dividend bit per cycle. The input is not ready while a word is in hand.
// The output register holds a finished word while the receiver stalls; the block
// accepts further input meanwhile and stalls only if a second result is ready
// before the first is taken. The configuration channel is always ready; the user
// must see that it is written only while idle; the block does not enforce this.
// Synchronous reset clears the running hash, both registers and all control.
module sdbm_string_hash_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [7:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_char_byte,
    input  logic                          i_first_of_name,
    input  logic                          i_last_of_name,
    input  logic                          i_no_chars,
    input  logic signed [31:0]            i_seed,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sdbm_pkg::C_HASH_W-1:0] o_hash_value
);

    localparam logic [7:0] C_REG_FOLD_CASE  = 8'd0;
    localparam logic [7:0] C_REG_TABLE_SIZE = 8'd1;

    localparam int         C_SHIFT_A  = 6;
    localparam int         C_SHIFT_B  = 16;
    localparam logic [7:0] C_LOWER_A  = 8'h61;
    localparam logic [7:0] C_LOWER_Z  = 8'h7a;
    localparam logic [7:0] C_UPPER_A  = 8'h41;
    localparam logic [7:0] C_CASE_GAP = C_LOWER_A - C_UPPER_A;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FOLD = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                    r_state;
    logic                          r_fold_case;
    logic [sdbm_pkg::C_SIZE_W-1:0] r_table_size;
    logic [sdbm_pkg::C_HASH_W-1:0] r_hash;
    logic [7:0]                    r_byte;
    logic                          r_first;
    logic                          r_last;
    logic                          r_empty;
    logic [31:0]                   r_seed;
    logic [sdbm_pkg::C_HASH_W-1:0] r_res;
    logic                          r_out_valid;
    logic [sdbm_pkg::C_HASH_W-1:0] r_out_hash;

    logic                          in_accept;
    logic                          out_free;
    logic                          mod_start;
    sdbm_pkg::t_mod_stat           mod_stat;
    logic [sdbm_pkg::C_SIZE_W-1:0] mod_rem;
    logic [7:0]                    byte_used;
    logic [sdbm_pkg::C_HASH_W-1:0] h_base;
    logic [sdbm_pkg::C_HASH_W-1:0] h_fold;
    logic [sdbm_pkg::C_HASH_W-1:0] n_hash;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign mod_start = (r_state == S_FOLD) && r_last && (r_table_size != '0);

    // Byte fold of the held word. The seed is sign-extended to the hash width.
    always_comb begin
        byte_used = r_byte;
        if (r_fold_case && (r_byte inside {[C_LOWER_A:C_LOWER_Z]})) begin
            byte_used = r_byte - C_CASE_GAP;
        end
        h_base = r_first ? {{(sdbm_pkg::C_HASH_W - 32){r_seed[31]}}, r_seed} : r_hash;
        h_fold = (h_base << C_SHIFT_A) + (h_base << C_SHIFT_B) - h_base
               + {{(sdbm_pkg::C_HASH_W - 8){1'b0}}, byte_used};
        n_hash = r_empty ? h_base : h_fold;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case  <= 1'b0;
            r_table_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                C_REG_FOLD_CASE:  r_fold_case  <= i_cfg_data[0];
                C_REG_TABLE_SIZE: r_table_size <= i_cfg_data[sdbm_pkg::C_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and running hash.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_hash <= n_hash;
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (mod_start) begin
                        r_state <= S_MOD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MOD: begin
                    if (mod_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte  <= i_char_byte;
            r_first <= i_first_of_name;
            r_last  <= i_last_of_name;
            r_empty <= i_no_chars;
            r_seed  <= i_seed;
        end
        if (r_state == S_FOLD) begin
            r_res <= n_hash;
        end else if (r_state == S_MOD && mod_stat.done) begin
            r_res <= {{(sdbm_pkg::C_HASH_W - sdbm_pkg::C_SIZE_W){1'b0}}, mod_rem};
        end
        if (r_state == S_OUT && out_free) begin
            r_out_hash <= r_res;
        end
    end

    sdbm_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (n_hash),
        .i_divisor  (r_table_size),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

`ifndef SYNTHESIS
    a_accept_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_FOLD))
        else $error("accepted word not folded next cycle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=>
        (r_state == S_OUT && o_out_valid))
        else $error("result dropped while output stalled");
    a_mod_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_stat.busy |-> (r_state == S_MOD))
        else $error("remainder unit busy outside its state");
`endif

endmodule
